[rtl/fdr_pkg.sv]
`default_nettype none
package fdr_pkg;

  localparam int PIXEL_W        = 32;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int COORD_W        = 10;
  // wide enough for a clamped frame size of up to 4096
  localparam int SIZE_W         = 13;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int RES_Q_DEPTH    = 3;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic               frame_changed;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
  } fdr_result_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0]  v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] ve;
    ve = SIZE_W'(v);
    if (v == '0) begin
      return SIZE_W'(1);
    end else if (ve > maxv) begin
      return maxv;
    end
    return ve;
  endfunction

endpackage
`default_nettype wire

[rtl/fdr_if.sv]
`default_nettype none
interface fdr_pix_if;
  import fdr_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface fdr_res_if;
  import fdr_pkg::*;
  logic               valid;
  logic               ready;
  logic               frame_changed;
  logic [COORD_W-1:0] box_left;
  logic [COORD_W-1:0] box_top;
  logic [COORD_W-1:0] box_right;
  logic [COORD_W-1:0] box_bottom;

  modport source (output valid, output frame_changed, output box_left, output box_top,
                  output box_right, output box_bottom, input ready);
  modport sink (input valid, input frame_changed, input box_left, input box_top,
                input box_right, input box_bottom, output ready);
endinterface

interface fdr_cfg_if;
  import fdr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface
`default_nettype wire

[rtl/fdr_snap_ram.sv]
`default_nettype none
module fdr_snap_ram #(
  parameter int DEPTH = 1048576,
  parameter int AW    = 20
) (
  input  wire  logic                        clk,
  input  wire  logic                        rst_n,
  input  wire  logic                        rd_en,
  input  wire  logic [AW-1:0]               rd_addr,
  output logic [fdr_pkg::PIXEL_W-1:0]       rd_data,
  input  wire  logic                        wr_en,
  input  wire  logic [AW-1:0]               wr_addr,
  input  wire  logic [fdr_pkg::PIXEL_W-1:0] wr_data,
  output logic                              clr_busy
);
  import fdr_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rd_data_r;
  logic               clr_busy_r;
  logic [AW-1:0]      clr_addr_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [PIXEL_W-1:0] mem_wdata;

  // clearing sweep owns the write port until every entry is zero
  always_comb begin
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule
`default_nettype wire

[rtl/fdr_box_acc.sv]
`default_nettype none
module fdr_box_acc #(
  parameter int CW = 10,
  parameter int RW = 10
) (
  input  wire  logic          clk,
  input  wire  logic          rst_n,
  input  wire  logic          upd,
  input  wire  logic          differ,
  input  wire  logic [CW-1:0] col,
  input  wire  logic [RW-1:0] row,
  input  wire  logic          frame_end,
  output logic                res_valid,
  output fdr_pkg::fdr_result_t res
);
  import fdr_pkg::*;

  logic          any_r, any_nxt, any_new;
  logic [CW-1:0] min_col_r, min_col_nxt, min_col_new;
  logic [CW-1:0] max_col_r, max_col_nxt, max_col_new;
  logic [RW-1:0] min_row_r, min_row_nxt, min_row_new;
  logic [RW-1:0] max_row_r, max_row_nxt, max_row_new;

  always_comb begin
    any_new     = any_r;
    min_col_new = min_col_r;
    max_col_new = max_col_r;
    min_row_new = min_row_r;
    max_row_new = max_row_r;
    if (upd && differ) begin
      any_new = 1'b1;
      if (!any_r) begin
        min_col_new = col;
        max_col_new = col;
        min_row_new = row;
        max_row_new = row;
      end else begin
        if (col < min_col_r) min_col_new = col;
        if (col > max_col_r) max_col_new = col;
        if (row < min_row_r) min_row_new = row;
        if (row > max_row_r) max_row_new = row;
      end
    end

    res_valid = upd && frame_end;
    res.frame_changed = any_new;
    res.box_left      = any_new ? COORD_W'(min_col_new) : '0;
    res.box_top       = any_new ? COORD_W'(min_row_new) : '0;
    res.box_right     = any_new ? COORD_W'(max_col_new) : '0;
    res.box_bottom    = any_new ? COORD_W'(max_row_new) : '0;

    // accumulators start over after the last pixel of a frame
    if (res_valid) begin
      any_nxt     = 1'b0;
      min_col_nxt = '0;
      max_col_nxt = '0;
      min_row_nxt = '0;
      max_row_nxt = '0;
    end else begin
      any_nxt     = any_new;
      min_col_nxt = min_col_new;
      max_col_nxt = max_col_new;
      min_row_nxt = min_row_new;
      max_row_nxt = max_row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r     <= 1'b0;
      min_col_r <= '0;
      max_col_r <= '0;
      min_row_r <= '0;
      max_row_r <= '0;
    end else begin
      any_r     <= any_nxt;
      min_col_r <= min_col_nxt;
      max_col_r <= max_col_nxt;
      min_row_r <= min_row_nxt;
      max_row_r <= max_row_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/fdr_res_fifo.sv]
`default_nettype none
module fdr_res_fifo #(
  parameter int DEPTH = 3,
  parameter int PW    = 2,
  parameter int CNTW  = 2
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst_n,
  input  wire  logic                  push,
  input  wire  fdr_pkg::fdr_result_t  push_data,
  input  wire  logic                  pop,
  output logic                        head_valid,
  output fdr_pkg::fdr_result_t        head_data,
  output logic [CNTW-1:0]             count
);
  import fdr_pkg::*;

  fdr_result_t     q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = q_r[rd_ptr_r];
  assign count      = cnt_r;

endmodule
`default_nettype wire

[rtl/frame_dirty_rectangle_detector_unit.sv]
`default_nettype none
// frame dirty-rectangle detector
// in_pix: one 32-bit pixel per request, raster order; column and row are
//   counted inside from frame_width and frame_height (0 acts as 1, values
//   above MAX_WIDTH / MAX_HEIGHT act as the maximum)
// out_res: one request after the last pixel of every frame, carrying the
//   changed flag and the bounding box of differing pixels (all zero when
//   nothing changed)
// cfg_wr: register index 0 is frame_width, 1 is frame_height, others ignored;
//   always ready, write only while no frame pixel is in flight
// result path: compare stage registers, then the result queue, then out_res
// throughput: one pixel per cycle while in_pix.ready is high; each pixel costs
//   one snapshot ram read when accepted and, if it differs, one write back in
//   the cycle after, forwarded to a next pixel on the same entry (1x1 frames)
// reset: the snapshot ram's MAX_WIDTH * MAX_HEIGHT entries (1048576 by
//   default) are swept to zero one entry a cycle; in_pix.ready stays low
//   until the sweep ends, configuration writes are still taken
// stall: a three-deep result queue sits before out_res; pixels keep flowing
//   until queued plus in-flight results fill it
module frame_dirty_rectangle_detector_unit #(
  parameter int MAX_WIDTH  = fdr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdr_pkg::DEF_MAX_HEIGHT
) (
  input wire logic clk,
  input wire logic rst_n,
  fdr_pix_if.sink   in_pix,
  fdr_res_if.source out_res,
  fdr_cfg_if.sink   cfg_wr
);
  import fdr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int QPW   = $clog2(RES_Q_DEPTH);
  localparam int QCW   = $clog2(RES_Q_DEPTH + 1);

  // configuration registers
  logic [CFG_W-1:0]  frame_width_r;
  logic [CFG_W-1:0]  frame_height_r;
  logic [SIZE_W-1:0] width_eff;
  logic [SIZE_W-1:0] height_eff;

  // raster position of the next pixel
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // accept stage
  logic          in_acc;
  logic          clr_busy;
  logic [AW-1:0] s0_addr;
  logic          s0_row_end;
  logic          s0_frame_end;
  logic          s0_fwd;

  // compare stage, in the cycle after the ram read is issued
  logic               s1_valid_r;
  logic [AW-1:0]      s1_addr_r;
  logic [PIXEL_W-1:0] s1_pix_r;
  logic [CW-1:0]      s1_col_r;
  logic [RW-1:0]      s1_row_r;
  logic               s1_end_r;
  logic               s1_fwd_r;
  logic [PIXEL_W-1:0] s1_fwd_data_r;
  logic [PIXEL_W-1:0] ram_rd_data;
  logic [PIXEL_W-1:0] s1_old;
  logic               s1_differ;

  // result path
  logic             res_valid;
  fdr_result_t      res_data;
  logic             q_pop;
  logic             q_head_valid;
  fdr_result_t      q_head;
  logic [QCW-1:0]   q_count;
  logic [QCW:0]     q_occ;

  // configuration writes, unknown indices dropped
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_SIZE_RESET;
      frame_height_r <= CFG_SIZE_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.reg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wr.reg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wr.reg_data;
        default: ;
      endcase
    end
  end

  assign width_eff  = clamp_size(frame_width_r, SIZE_W'(MAX_WIDTH));
  assign height_eff = clamp_size(frame_height_r, SIZE_W'(MAX_HEIGHT));

  // results queued or still in the compare stage must fit in the queue
  assign q_occ       = (QCW + 1)'(q_count) + (QCW + 1)'(s1_valid_r && s1_end_r);
  assign in_pix.ready = !clr_busy && (q_occ < (QCW + 1)'(RES_Q_DEPTH));
  assign in_acc       = in_pix.valid && in_pix.ready;

  // raster counting; a counter past a freshly shrunk size ends its row here
  always_comb begin
    s0_addr      = AW'(AW'(row_r) * AW'(MAX_WIDTH) + AW'(col_r));
    s0_row_end   = (SIZE_W'(col_r) + SIZE_W'(1)) >= width_eff;
    s0_frame_end = s0_row_end && ((SIZE_W'(row_r) + SIZE_W'(1)) >= height_eff);
    if (s0_frame_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (s0_row_end) begin
      col_nxt = '0;
      row_nxt = row_r + RW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
    // the entry being written back this cycle ends up holding the older pixel
    s0_fwd = s1_valid_r && (s1_addr_r == s0_addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r     <= s0_addr;
      s1_pix_r      <= in_pix.pixel_value;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      s1_end_r      <= s0_frame_end;
      s1_fwd_r      <= s0_fwd;
      s1_fwd_data_r <= s1_pix_r;
    end
  end

  assign s1_old    = s1_fwd_r ? s1_fwd_data_r : ram_rd_data;
  assign s1_differ = (s1_old != s1_pix_r);

  fdr_snap_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_snap_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (s0_addr),
    .rd_data  (ram_rd_data),
    .wr_en    (s1_valid_r && s1_differ),
    .wr_addr  (s1_addr_r),
    .wr_data  (s1_pix_r),
    .clr_busy (clr_busy)
  );

  fdr_box_acc #(
    .CW (CW),
    .RW (RW)
  ) u_box_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (s1_valid_r),
    .differ    (s1_differ),
    .col       (s1_col_r),
    .row       (s1_row_r),
    .frame_end (s1_end_r),
    .res_valid (res_valid),
    .res       (res_data)
  );

  assign q_pop = q_head_valid && out_res.ready;

  fdr_res_fifo #(
    .DEPTH (RES_Q_DEPTH),
    .PW    (QPW),
    .CNTW  (QCW)
  ) u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res_data),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head),
    .count      (q_count)
  );

  assign out_res.valid         = q_head_valid;
  assign out_res.frame_changed = q_head.frame_changed;
  assign out_res.box_left      = q_head.box_left;
  assign out_res.box_top       = q_head.box_top;
  assign out_res.box_right     = q_head.box_right;
  assign out_res.box_bottom    = q_head.box_bottom;

`ifndef SYNTH
  // no pixel may reach the ram while the clearing sweep still owns it
  a_no_pixel_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !clr_busy)
    else $error("pixel accepted during snapshot clear");

  // the result queue never takes a result it has no room for
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !q_pop) |-> (q_count < QCW'(RES_Q_DEPTH)))
    else $error("result queue overflow");

  // the pixel after a frame's last one starts at the origin again
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s0_frame_end) |=> (col_r == '0 && row_r == '0))
    else $error("raster position not reset at frame end");

  // an unchanged frame reports an all-zero box
  a_unchanged_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.frame_changed) |->
      (out_res.box_left == '0 && out_res.box_top == '0 &&
       out_res.box_right == '0 && out_res.box_bottom == '0))
    else $error("non-zero box on unchanged frame");
`endif

endmodule
`default_nettype wire
